// ===== design/stg_pkg.sv =====
// types and constants shared by the square tone generator
package stg_pkg;

  localparam int FREQ_W     = 15;
  localparam int VOL_W      = 8;
  localparam int TIME_W     = 32;
  localparam int PHASE_W    = 16;
  localparam int ACC_W      = 17;
  localparam int MAG_W      = 12;
  localparam int SAMPLE_W   = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int RECIP_W    = 24;
  localparam int PROD_W     = 32;
  localparam int VOL_SHIFT  = 20;

  localparam logic [FREQ_W-1:0]  FREQ_MAX   = 15'd22050;
  localparam logic [ACC_W-1:0]   TONE_RATE  = 17'd44100;
  localparam logic [PHASE_W-1:0] HALF_RATE  = 16'd22050;
  localparam logic [MAG_W-1:0]   MAG_MAX    = 12'd3000;
  localparam logic [MAG_W-1:0]   MAG_RESET  = 12'd1505;
  localparam logic [RECIP_W-1:0] VOL_RECIP  = 24'd12336200;

  localparam logic [CFG_IDX_W-1:0] REG_TONE_FREQUENCY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_VOLUME  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_TIME_MS   = 2'd2;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [MAG_W-1:0]  mag;
    logic [TIME_W-1:0] stop_time;
  } cfg_t;

endpackage

// ===== design/stg_if.sv =====
// valid/ready channel interfaces of the square tone generator
interface stg_in_if;
  logic                      valid;
  logic                      ready;
  logic [stg_pkg::TIME_W-1:0] now_ms;
  logic                      buffer_end;
  modport source (output valid, output now_ms, output buffer_end, input ready);
  modport sink   (input valid, input now_ms, input buffer_end, output ready);
endinterface

interface stg_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [stg_pkg::SAMPLE_W-1:0] sample;
  logic                               last_of_buffer;
  modport source (output valid, output sample, output last_of_buffer, input ready);
  modport sink   (input valid, input sample, input last_of_buffer, output ready);
endinterface

interface stg_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [stg_pkg::CFG_IDX_W-1:0]  index;
  logic [stg_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/stg_cfg_regs.sv =====
// configuration registers with frequency clamp and volume-to-magnitude scaling
module stg_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  stg_cfg_if.sink       cfg,
  output stg_pkg::cfg_t regs
);
  import stg_pkg::*;

  logic [FREQ_W-1:0] freq_in;
  logic [FREQ_W-1:0] freq_next;
  logic [PROD_W-1:0] vol_prod;
  logic [MAG_W-1:0]  mag_next;
  logic              write;

  assign cfg.ready = 1'b1;
  assign write     = cfg.valid && cfg.ready;
  assign freq_in   = cfg.data[FREQ_W-1:0];
  assign freq_next = (freq_in > FREQ_MAX) ? FREQ_MAX : freq_in;

  // 3000 * vol / 255 via reciprocal, exact over the 8-bit range
  assign vol_prod = {{(PROD_W-VOL_W){1'b0}}, cfg.data[VOL_W-1:0]} *
                    {{(PROD_W-RECIP_W){1'b0}}, VOL_RECIP};
  assign mag_next = vol_prod[VOL_SHIFT+MAG_W-1:VOL_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.freq      <= '0;
      regs.mag       <= MAG_RESET;
      regs.stop_time <= '0;
    end else if (write) begin
      unique case (cfg.index)
        REG_TONE_FREQUENCY: regs.freq      <= freq_next;
        REG_OUTPUT_VOLUME:  regs.mag       <= mag_next;
        REG_STOP_TIME_MS:   regs.stop_time <= cfg.data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/square_tone_generator.sv =====
// top level of the square tone generator
//
// channel  dir  transfer when          payload
// cfg      in   cfg.valid & ready      index, data
// tick     in   tick.valid & ready     now_ms, buffer_end
// result   out  result.valid & ready   sample, last_of_buffer
//
// one tick in, one sample out; a tick is taken every cycle unless the result
// register is full and stalled; it holds each sample from the cycle after the transfer
// tick.ready drops only while the result register is full and stalled
// cfg is always ready; a write is in effect for the next tick
// rst is synchronous: phase clears, volume returns to 128, frequency and stop time to 0
module square_tone_generator (
  input  logic     clk,
  input  logic     rst,
  stg_cfg_if.sink  cfg,
  stg_in_if.sink   tick,
  stg_out_if.source result
);
  import stg_pkg::*;

  cfg_t                       regs;
  logic                       accept;
  logic                       sounding;
  logic [ACC_W-1:0]           acc_sum;
  logic [ACC_W-1:0]           acc_wrap;
  logic [PHASE_W-1:0]         phase;
  logic [PHASE_W-1:0]         phase_next;
  logic signed [SAMPLE_W-1:0] mag_s;
  logic signed [SAMPLE_W-1:0] sample_next;
  logic                       result_valid;
  logic signed [SAMPLE_W-1:0] sample_reg;
  logic                       last_reg;

  stg_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  assign tick.ready = !result_valid || result.ready;
  assign accept     = tick.valid && tick.ready;

  assign sounding = (regs.freq != '0) &&
                    ((regs.stop_time == '0) || (tick.now_ms < regs.stop_time));

  assign acc_sum  = {1'b0, phase} + {{(ACC_W-FREQ_W){1'b0}}, regs.freq};
  assign acc_wrap = (acc_sum >= TONE_RATE) ? (acc_sum - TONE_RATE) : acc_sum;

  assign mag_s = $signed({{(SAMPLE_W-MAG_W){1'b0}}, regs.mag});

  always_comb begin
    phase_next  = '0;
    sample_next = '0;
    if (sounding) begin
      phase_next  = acc_wrap[PHASE_W-1:0];
      sample_next = (phase_next < HALF_RATE) ? mag_s : -mag_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        result_valid <= 1'b1;
      end else if (result.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_reg <= sample_next;
      last_reg   <= tick.buffer_end;
    end
  end

  assign result.valid          = result_valid;
  assign result.sample         = sample_reg;
  assign result.last_of_buffer = last_reg;

`ifndef SYNTH
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, phase} < TONE_RATE)
    else $error("phase accumulator out of range");

  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((sample_reg <= $signed({1'b0, MAG_MAX})) &&
                      (sample_reg >= -$signed({1'b0, MAG_MAX}))))
    else $error("sample beyond amplitude");

  a_silent_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && !sounding) |=> (phase == '0) && (sample_reg == '0))
    else $error("silent tick left phase or sample nonzero");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("tick transfer produced no result");
`endif

endmodule

// ===== tb/tone_checker.sv =====
// checker for the square tone generator: predicts every sample and compares results
`timescale 1ns / 1ps

module tone_checker
  import stg_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       tick_valid,
  input  logic                       tick_ready,
  input  logic [TIME_W-1:0]          now_ms,
  input  logic                       buffer_end,
  input  logic                       result_valid,
  input  logic                       result_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last_of_buffer,
  output int                         errors,
  output int                         checked,
  output int                         outstanding
);

  localparam int               VOL_FULL   = 255;
  localparam logic [VOL_W-1:0] VOL_RESET  = 8'd128;
  localparam int               PEND_DEPTH = 256;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } tone_out_t;

  logic [FREQ_W-1:0]  freq_q;
  logic [VOL_W-1:0]   vol_q;
  logic [TIME_W-1:0]  stop_q;
  logic [PHASE_W-1:0] phase_q;
  tone_out_t          pending_samples[PEND_DEPTH];
  logic [7:0]         pend_wr;
  logic [7:0]         pend_rd;
  int                 pend_count;

  // advances the phase and returns the sample for one tick
  function automatic logic signed [SAMPLE_W-1:0] next_tone_sample(input logic [TIME_W-1:0] now);
    logic [ACC_W-1:0]    acc;
    logic [SAMPLE_W-1:0] mag;
    if (freq_q == '0 || (stop_q != '0 && now >= stop_q)) begin
      phase_q = '0;
      return '0;
    end
    acc = ACC_W'(phase_q) + ACC_W'(freq_q);
    if (acc >= TONE_RATE) begin
      acc = acc - TONE_RATE;
    end
    phase_q = acc[PHASE_W-1:0];
    mag = SAMPLE_W'((int'(MAG_MAX) * int'(vol_q)) / VOL_FULL);
    return (2 * int'(phase_q) < int'(TONE_RATE)) ? mag : -mag;
  endfunction

  always @(posedge clk) begin : watch
    tone_out_t want;
    if (rst) begin
      freq_q     = '0;
      vol_q      = VOL_RESET;
      stop_q     = '0;
      phase_q    = '0;
      pend_wr    = '0;
      pend_rd    = '0;
      pend_count = 0;
    end else begin
      // a tick uses the settings from before a write at the same edge
      if (tick_valid && tick_ready) begin
        want.sample = next_tone_sample(now_ms);
        want.last   = buffer_end;
        if (pend_count < PEND_DEPTH) begin
          pending_samples[pend_wr] = want;
          pend_wr = pend_wr + 8'd1;
          pend_count++;
        end else begin
          $display("%0t too many samples pending: expected at most %0d, actual %0d",
                   $time, PEND_DEPTH, pend_count + 1);
          errors++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TONE_FREQUENCY: begin
            freq_q = (cfg_data[FREQ_W-1:0] > FREQ_MAX) ? FREQ_MAX : cfg_data[FREQ_W-1:0];
          end
          REG_OUTPUT_VOLUME: begin
            vol_q = cfg_data[VOL_W-1:0];
          end
          REG_STOP_TIME_MS: begin
            stop_q = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (result_valid && result_ready) begin
        if (pend_count == 0) begin
          $display("%0t unexpected result transfer: expected none, actual sample %0d last %0b",
                   $time, sample, last_of_buffer);
          errors++;
        end else begin
          want = pending_samples[pend_rd];
          pend_rd = pend_rd + 8'd1;
          pend_count--;
          if (sample !== want.sample) begin
            $display("%0t sample mismatch: expected %0d, actual %0d",
                     $time, $signed(want.sample), sample);
            errors++;
          end
          if (last_of_buffer !== want.last) begin
            $display("%0t last_of_buffer mismatch: expected %0b, actual %0b",
                     $time, want.last, last_of_buffer);
            errors++;
          end
          checked++;
        end
      end
    end
    outstanding = pend_count;
  end

endmodule

// ===== tb/square_tone_generator_test.sv =====
// top of the square tone generator testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module square_tone_generator_test;
  import stg_pkg::*;

  localparam int                   RANDOM_ITEMS = 950;
  localparam int                   TIMEOUT_NS   = 2_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;

  logic clk = 1'b0;
  logic rst;

  int errors;
  int checked;
  int outstanding;
  int ticks_sent;
  int settings;
  int unsigned sender_gap_pct   = 34;
  int unsigned receiver_stall_pct = 56;

  stg_cfg_if cfg_ch ();
  stg_in_if  tick_ch ();
  stg_out_if res_ch ();

  square_tone_generator dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .tick   (tick_ch),
    .result (res_ch)
  );

  tone_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_ch.valid),
    .cfg_ready      (cfg_ch.ready),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .tick_valid     (tick_ch.valid),
    .tick_ready     (tick_ch.ready),
    .now_ms         (tick_ch.now_ms),
    .buffer_end     (tick_ch.buffer_end),
    .result_valid   (res_ch.valid),
    .result_ready   (res_ch.ready),
    .sample         (res_ch.sample),
    .last_of_buffer (res_ch.last_of_buffer),
    .errors         (errors),
    .checked        (checked),
    .outstanding    (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_tick(input logic [TIME_W-1:0] now, input logic last);
    while ($urandom_range(99) < sender_gap_pct) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.now_ms     <= now;
    tick_ch.buffer_end <= last;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    ticks_sent++;
  endtask

  // stop sending and wait until every sample has come back
  task automatic drain_ticks();
    tick_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic set_tone(input logic [CFG_DATA_W-1:0] freq, input logic [CFG_DATA_W-1:0] vol,
                          input logic [CFG_DATA_W-1:0] stop);
    drain_ticks();
    write_reg(REG_TONE_FREQUENCY, freq);
    write_reg(REG_OUTPUT_VOLUME, vol);
    write_reg(REG_STOP_TIME_MS, stop);
    cfg_ch.valid <= 1'b0;
    settings++;
  endtask

  initial begin : stimulus
    logic [TIME_W-1:0]     now_base;
    logic [CFG_DATA_W-1:0] freq_word;
    logic [CFG_DATA_W-1:0] vol_word;
    logic [CFG_DATA_W-1:0] stop_word;
    int unsigned           roll;
    int                    left;
    int                    blen;
    int                    j;
    int                    directed_sent;
    int                    random_done;

    rst                <= 1'b1;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_TONE_FREQUENCY;
    cfg_ch.data        <= '0;
    tick_ch.valid      <= 1'b0;
    tick_ch.now_ms     <= '0;
    tick_ch.buffer_end <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // silent after reset
    send_tick('0, 1'b0);
    send_tick('1, 1'b1);

    // clamped frequency at full volume
    set_tone(32767, 255, 0);
    send_tick(32'd10, 1'b0);
    send_tick(32'd10, 1'b0);
    send_tick(32'd10, 1'b0);
    send_tick(32'd10, 1'b1);

    // write to an unused index changes nothing
    drain_ticks();
    write_reg(REG_UNUSED, '1);
    cfg_ch.valid <= 1'b0;
    send_tick(32'd11, 1'b0);
    send_tick(32'd11, 1'b1);

    // zero volume keeps the phase running
    set_tone(FREQ_MAX, 0, 0);
    send_tick(32'd12, 1'b0);
    send_tick(32'd12, 1'b1);
    set_tone(FREQ_MAX, 1, 0);
    send_tick(32'd13, 1'b0);
    send_tick(32'd13, 1'b1);

    // stop time reached clears the phase
    set_tone(11025, 128, 1000);
    send_tick(32'd999, 1'b0);
    send_tick(32'd999, 1'b1);
    send_tick(32'd1000, 1'b1);
    send_tick(32'd5, 1'b1);

    // stop time at the top of the range
    set_tone(12345, 200, '1);
    send_tick(32'hFFFF_FFFE, 1'b1);
    send_tick(32'hFFFF_FFFF, 1'b1);
    send_tick('0, 1'b1);

    set_tone(0, 255, 0);
    send_tick(32'd77, 1'b1);

    set_tone(1, 255, 0);
    send_tick(32'd78, 1'b0);
    send_tick(32'd78, 1'b0);
    send_tick(32'd78, 1'b1);

    directed_sent = ticks_sent;
    now_base = '0;
    while (ticks_sent < directed_sent + RANDOM_ITEMS) begin
      random_done = ticks_sent - directed_sent;
      if (random_done < RANDOM_ITEMS / 3) begin
        sender_gap_pct     = 34;
        receiver_stall_pct = 56;
      end else if (random_done < 2 * RANDOM_ITEMS / 3) begin
        sender_gap_pct     = 56;
        receiver_stall_pct = 34;
      end else begin
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
      end

      roll = $urandom_range(9);
      case (roll)
        0:       now_base = $urandom;
        1:       now_base = $urandom;
        2:       now_base = $urandom_range(50);
        3:       now_base = 32'hFFFF_FFFF - $urandom_range(50);
        default: now_base = now_base + $urandom_range(5, 1);
      endcase

      roll = $urandom_range(9);
      case (roll)
        0:       freq_word = 0;
        1:       freq_word = FREQ_MAX;
        2:       freq_word = $urandom_range(32767, 22051);
        3:       freq_word = $urandom_range(10, 1);
        4, 5:    freq_word = $urandom_range(2000, 1);
        default: freq_word = $urandom_range(22050);
      endcase
      if ($urandom_range(3) == 0) begin
        freq_word = freq_word | ($urandom << FREQ_W);
      end

      roll = $urandom_range(9);
      case (roll)
        0, 1:    vol_word = 0;
        2, 3:    vol_word = 255;
        default: vol_word = $urandom_range(255);
      endcase
      if ($urandom_range(3) == 0) begin
        vol_word = vol_word | ($urandom << VOL_W);
      end

      roll = $urandom_range(9);
      case (roll)
        5, 6, 7: stop_word = now_base + $urandom_range(40);
        8:       stop_word = $urandom;
        9:       stop_word = '1;
        default: stop_word = 0;
      endcase

      set_tone(freq_word, vol_word, stop_word);

      // buffers of ticks sharing one time, with some stray ticks mixed in
      left = $urandom_range(48, 8);
      while (left > 0) begin
        if ($urandom_range(9) == 0) begin
          send_tick($urandom, $urandom_range(1));
          left--;
        end else begin
          blen = $urandom_range(16, 1);
          for (j = 0; j < blen && left > 0; j++) begin
            send_tick(now_base, (j == blen - 1));
            left--;
          end
          now_base = now_base + $urandom_range(3, 1);
        end
      end
    end

    drain_ticks();
    repeat (4) @(negedge clk);
    $display("covered %0d ticks (%0d directed) over %0d tone settings, %0d samples checked",
             ticks_sent, directed_sent, settings, checked);
    $display("stall phases: sender-heavy, receiver-heavy and back-to-back transfers");
    if (errors == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
